[sv/wl512_pkg.sv]
// Shared types, constants and seed-expansion helpers for the WELL512 generator.
package wl512_pkg;

  localparam logic [31:0] LCG_MUL  = 32'd1103515245;
  localparam logic [31:0] LCG_ADD  = 32'd12345;
  localparam logic [31:0] LCG_MASK = 32'h7fff_ffff;
  localparam logic [31:0] MIX_MASK = 32'hDA44_2D20;

  // Ring tap offsets relative to the current ring position.
  localparam logic [3:0] OFS_M1   = 4'd13;
  localparam logic [3:0] OFS_M2   = 4'd9;
  localparam logic [3:0] OFS_PREV = 4'd15;
  localparam logic [3:0] LAST_IDX = 4'd15;

  typedef enum logic {
    CMD_DRAW = 1'b0,
    CMD_SEED = 1'b1
  } cmd_kind_t;

  // One classified command as it travels from the front to the back.
  typedef struct packed {
    cmd_kind_t          kind;
    logic [31:0]        seed;
    logic signed [31:0] lo;
    logic [31:0]        span;
    logic               err;
  } cmd_t;

  typedef logic [15:0][31:0] ring_t;

  function automatic logic [31:0] lcg_next(input logic [31:0] x);
    logic [31:0] t;
    t = x * LCG_MUL + LCG_ADD;
    return t & LCG_MASK;
  endfunction

  function automatic ring_t seed_table(input logic [31:0] seed);
    ring_t t;
    t[0] = seed;
    for (int i = 1; i < 16; i++) begin
      t[i] = lcg_next(t[i-1]);
    end
    return t;
  endfunction

  // Ring contents after reset: the expansion of seed zero.
  localparam ring_t RESET_RING = seed_table(32'd0);

endpackage

[sv/wl512_front.sv]
// Input side: accepts beats, classifies them and queues commands for the back end.
module wl512_front #(
  parameter int Depth = 2
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               func,
  input  logic [31:0]        seed_word,
  input  logic signed [31:0] range_min,
  input  logic signed [31:0] range_max,
  output logic               cmd_valid,
  output wl512_pkg::cmd_t    cmd,
  input  logic               cmd_pop
);
  import wl512_pkg::*;

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

  cmd_t            queue [Depth];
  logic [PtrW-1:0] wr_ptr;
  logic [PtrW-1:0] rd_ptr;
  logic [CntW-1:0] count;
  cmd_t            new_cmd;
  logic signed [32:0] diff;
  logic            push;

  // The span is formed in 33 bits; a positive span always fits in 32.
  always_comb begin
    diff          = {range_max[31], range_max} - {range_min[31], range_min};
    new_cmd.kind  = func ? CMD_SEED : CMD_DRAW;
    new_cmd.seed  = seed_word;
    new_cmd.lo    = range_min;
    new_cmd.span  = diff[31:0];
    new_cmd.err   = diff[32] || (diff == 33'sd0);
  end

  assign in_ready  = (count != FullCnt);
  assign push      = in_valid && in_ready;
  assign cmd_valid = (count != '0);
  assign cmd       = queue[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      queue[wr_ptr] <= new_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == LastPtr) ? '0 : wr_ptr + 1'b1;
      end
      if (cmd_pop) begin
        rd_ptr <= (rd_ptr == LastPtr) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !cmd_pop) begin
        count <= count + 1'b1;
      end else if (!push && cmd_pop) begin
        count <= count - 1'b1;
      end
    end
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (rst) count <= FullCnt)
    else $error("command queue count exceeds its depth");
  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst) cmd_pop |-> cmd_valid)
    else $error("command popped from an empty queue");
  a_push_fills: assert property (@(posedge clk) disable iff (rst) push |=> count != '0)
    else $error("queue empty right after a beat was taken");
`endif

endmodule

[sv/wl512_back.sv]
// Execution side: ring memory, reseed chain, WELL512 step, range scaling and result register.
module wl512_back (
  input  logic               clk,
  input  logic               rst,
  input  logic               cmd_valid,
  input  wl512_pkg::cmd_t    cmd,
  output logic               cmd_pop,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [31:0]        raw_word,
  output logic signed [31:0] scaled_value,
  output logic               range_error
);
  import wl512_pkg::*;

  typedef enum logic [7:0] {
    ST_IDLE = 8'b0000_0001,
    ST_SEED = 8'b0000_0010,
    ST_LCG  = 8'b0000_0100,
    ST_RD0  = 8'b0000_1000,
    ST_RD1  = 8'b0001_0000,
    ST_MIX  = 8'b0010_0000,
    ST_WR   = 8'b0100_0000,
    ST_OUT  = 8'b1000_0000
  } state_t;

  state_t      state;
  state_t      state_next;
  cmd_t        cur;
  logic [3:0]  ring_pos;
  logic [3:0]  lcg_idx;
  logic [31:0] lcg_x;
  logic [31:0] lcg_x_next;

  // Ring memory: one write port, two registered read ports.
  logic [31:0] ring_mem [16];
  logic [15:0] ring_valid;
  logic        ring_we;
  logic [3:0]  ring_waddr;
  logic [31:0] ring_wdata;
  logic [3:0]  ra;
  logic [3:0]  rb;
  logic [3:0]  ra_q;
  logic [3:0]  rb_q;
  logic        ra_valid_q;
  logic        rb_valid_q;
  logic [31:0] ra_mem_q;
  logic [31:0] rb_mem_q;
  logic [31:0] rdata_a;
  logic [31:0] rdata_b;

  logic [31:0] z1;
  logic [31:0] z1_next;
  logic [31:0] z2;
  logic [31:0] n1;
  logic [31:0] mix;
  logic [31:0] n0;
  logic [31:0] raw;
  logic [63:0] prod;
  logic        out_load;

  always_ff @(posedge clk) begin
    if (ring_we) begin
      ring_mem[ring_waddr] <= ring_wdata;
    end
    ra_mem_q <= ring_mem[ra];
    rb_mem_q <= ring_mem[rb];
    ra_q     <= ra;
    rb_q     <= rb;
  end

  // An entry never written since reset reads as its seed-zero value.
  always_ff @(posedge clk) begin
    if (rst) begin
      ring_valid <= '0;
      ra_valid_q <= 1'b0;
      rb_valid_q <= 1'b0;
    end else begin
      if (ring_we) begin
        ring_valid[ring_waddr] <= 1'b1;
      end
      ra_valid_q <= ring_valid[ra];
      rb_valid_q <= ring_valid[rb];
    end
  end

  assign rdata_a = ra_valid_q ? ra_mem_q : RESET_RING[ra_q];
  assign rdata_b = rb_valid_q ? rb_mem_q : RESET_RING[rb_q];

  assign ra = (state == ST_RD0) ? ring_pos : ring_pos + OFS_M2;
  assign rb = (state == ST_RD0) ? ring_pos + OFS_M1 : ring_pos + OFS_PREV;

  // WELL512 datapath; rdata_a holds the ninth tap and rdata_b the previous word in ST_MIX.
  assign z1_next = rdata_a ^ rdata_b ^ (rdata_a << 16) ^ (rdata_b << 15);
  assign z2      = rdata_a ^ (rdata_a >> 11);
  assign n1      = z1 ^ z2;
  assign mix     = n1 ^ ((n1 << 5) & MIX_MASK);
  assign n0      = rdata_b ^ z1 ^ mix ^ (rdata_b << 2) ^ (z1 << 18) ^ (z2 << 28);

  assign lcg_x_next = lcg_next(lcg_x);

  always_comb begin
    ring_we    = 1'b0;
    ring_waddr = ring_pos;
    ring_wdata = raw;
    unique case (state)
      ST_SEED: begin
        ring_we    = 1'b1;
        ring_waddr = '0;
        ring_wdata = cur.seed;
      end
      ST_LCG: begin
        ring_we    = 1'b1;
        ring_waddr = lcg_idx;
        ring_wdata = lcg_x_next;
      end
      ST_MIX: begin
        ring_we    = 1'b1;
        ring_waddr = ring_pos;
        ring_wdata = n1;
      end
      ST_WR: begin
        ring_we    = 1'b1;
        ring_waddr = ring_pos + OFS_PREV;
        ring_wdata = raw;
      end
      default: begin
        ring_we = 1'b0;
      end
    endcase
  end

  assign cmd_pop  = (state == ST_IDLE) && cmd_valid;
  assign out_load = (state == ST_OUT) && (!out_valid || out_ready);

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (cmd_valid) begin
          state_next = (cmd.kind == CMD_SEED) ? ST_SEED : ST_RD0;
        end
      end
      ST_SEED: state_next = ST_LCG;
      ST_LCG: begin
        if (lcg_idx == LAST_IDX) begin
          state_next = ST_IDLE;
        end
      end
      ST_RD0:  state_next = ST_RD1;
      ST_RD1:  state_next = ST_MIX;
      ST_MIX:  state_next = ST_WR;
      ST_WR:   state_next = ST_OUT;
      ST_OUT: begin
        if (out_load) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      ring_pos  <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == ST_LCG && lcg_idx == LAST_IDX) begin
        ring_pos <= '0;
      end else if (state == ST_WR) begin
        ring_pos <= ring_pos + OFS_PREV;
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_pop) begin
      cur <= cmd;
    end
    if (state == ST_SEED) begin
      lcg_x   <= cur.seed;
      lcg_idx <= 4'd1;
    end else if (state == ST_LCG) begin
      lcg_x   <= lcg_x_next;
      lcg_idx <= lcg_idx + 4'd1;
    end
    if (state == ST_RD1) begin
      z1 <= z1_next;
    end
    if (state == ST_MIX) begin
      raw <= n0;
    end
    if (state == ST_WR) begin
      prod <= {32'd0, raw} * {32'd0, cur.span};
    end
    if (out_load) begin
      raw_word     <= raw;
      range_error  <= cur.err;
      scaled_value <= cur.err ? 32'sd0 : cur.lo + $signed(prod[63:32]);
    end
  end

`ifndef SYNTHESIS
  a_result_from_out: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == ST_OUT))
    else $error("result beat appeared outside the output step");
  a_pop_when_idle: assert property (@(posedge clk) disable iff (rst)
    cmd_pop |-> state == ST_IDLE)
    else $error("command taken while another is in progress");
  a_reseed_end: assert property (@(posedge clk) disable iff (rst)
    (state == ST_LCG && lcg_idx == LAST_IDX) |=> (state == ST_IDLE && ring_pos == '0))
    else $error("reseed did not finish with the ring position cleared");
`endif

endmodule

[sv/well512_random_generator.sv]
// Top level of the WELL512 generator: command queue front end and execution back end.
//
//   channel | handshake            | payload
//   --------+----------------------+-------------------------------------------------
//   input   | in_valid / in_ready  | func, seed_word, range_min, range_max
//   output  | out_valid / out_ready| raw_word, scaled_value, range_error
//
// A draw passes through the back end in order: taking the command, ring reads in ST_RD0
// and ST_RD1 on the two read ports, a mix step, a write-back and multiply step, and an
// output step that waits until the output register can be loaded.
// A reseed occupies it from taking the command until the last chained word is written:
// one write per cycle through the single ring write port, a 32-bit multiply-add for each
// of the fifteen chained words.
// After reset the ring reads as the expansion of seed zero at once; there is no
// clearing pass.
// While out_ready is low, a finished draw waits in the output register and the
// command queue keeps taking input beats until it is full.
module well512_random_generator #(
  parameter int QueueDepth = 2
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               func,
  input  logic [31:0]        seed_word,
  input  logic signed [31:0] range_min,
  input  logic signed [31:0] range_max,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [31:0]        raw_word,
  output logic signed [31:0] scaled_value,
  output logic               range_error
);
  import wl512_pkg::*;

  logic cmd_valid;
  logic cmd_pop;
  cmd_t cmd;

  wl512_front #(
    .Depth(QueueDepth)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .func      (func),
    .seed_word (seed_word),
    .range_min (range_min),
    .range_max (range_max),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_pop   (cmd_pop)
  );

  wl512_back u_back (
    .clk          (clk),
    .rst          (rst),
    .cmd_valid    (cmd_valid),
    .cmd          (cmd),
    .cmd_pop      (cmd_pop),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .raw_word     (raw_word),
    .scaled_value (scaled_value),
    .range_error  (range_error)
  );

endmodule

[tb/well512_random_generator_tb.sv]
// Self-checking testbench for the WELL512 generator: draws, reseeds and range scaling.
module well512_random_generator_tb;
  import wl512_pkg::*;

  localparam logic [31:0] INT_MIN_W = 32'h8000_0000;
  localparam logic [31:0] INT_MAX_W = 32'h7fff_ffff;
  localparam int NUM_RANDOM = 550;
  localparam int PHASE_LEN = 110;
  localparam int DRAIN_CYCLES = 40;

  typedef struct {
    logic [31:0] raw;
    logic [31:0] scaled;
    logic        err;
  } draw_result_t;

  // Tracks the generator ring and the draws that are still owed by the block.
  class draw_scoreboard;
    logic [31:0] ring [16];
    logic [3:0] pos;
    draw_result_t pending_draws[$];
    int errors;

    function new();
      errors = 0;
      load_seed(32'd0);
    endfunction

    function void load_seed(logic [31:0] seed);
      ring[0] = seed;
      for (int i = 1; i < 16; i++) begin
        ring[i] = (ring[i-1] * LCG_MUL + LCG_ADD) & LCG_MASK;
      end
      pos = 4'd0;
    endfunction

    function logic [31:0] next_word();
      logic [3:0] p;
      logic [3:0] tap;
      logic [31:0] v0, vm1, z0, z1, z2, n0, n1, mix;
      p = pos;
      v0 = ring[p];
      tap = p + OFS_M1;
      vm1 = ring[tap];
      z1 = v0 ^ vm1 ^ (v0 << 16) ^ (vm1 << 15);
      tap = p + OFS_M2;
      z2 = ring[tap];
      z2 = z2 ^ (z2 >> 11);
      n1 = z1 ^ z2;
      ring[p] = n1;
      mix = n1 ^ ((n1 << 5) & MIX_MASK);
      // The ring position steps back by one word on every draw.
      p = p + OFS_PREV;
      z0 = ring[p];
      n0 = z0 ^ z1 ^ mix ^ (z0 << 2) ^ (z1 << 18) ^ (z2 << 28);
      ring[p] = n0;
      pos = p;
      return n0;
    endfunction

    function void note_beat(logic f, logic [31:0] seed, logic [31:0] mn, logic [31:0] mx);
      draw_result_t r;
      longint lo, hi;
      logic [63:0] span, offs;
      if (f == CMD_SEED) begin
        load_seed(seed);
        return;
      end
      r.raw = next_word();
      lo = $signed(mn);
      hi = $signed(mx);
      if (hi <= lo) begin
        r.scaled = 32'd0;
        r.err = 1'b1;
      end else begin
        // Span fits in 32 bits and the product in 64, so this is an exact multiply-high.
        span = hi - lo;
        offs = ({32'd0, r.raw} * span) >> 32;
        r.scaled = mn + offs[31:0];
        r.err = 1'b0;
      end
      pending_draws.push_back(r);
    endfunction

    function void check_draw(logic [31:0] raw, logic [31:0] scaled, logic err);
      draw_result_t e;
      if (pending_draws.size() == 0) begin
        $display("%0t: unexpected result beat raw_word=%h scaled_value=%h range_error=%b",
                 $time, raw, scaled, err);
        errors++;
        return;
      end
      e = pending_draws.pop_front();
      if (raw !== e.raw) begin
        $display("%0t: raw_word expected %h actual %h", $time, e.raw, raw);
        errors++;
      end
      if (scaled !== e.scaled) begin
        $display("%0t: scaled_value expected %h actual %h", $time, e.scaled, scaled);
        errors++;
      end
      if (err !== e.err) begin
        $display("%0t: range_error expected %b actual %b", $time, e.err, err);
        errors++;
      end
    endfunction
  endclass

  logic clk;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  logic func = 1'b0;
  logic [31:0] seed_word = 32'd0;
  logic signed [31:0] range_min = 32'sd0;
  logic signed [31:0] range_max = 32'sd0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [31:0] raw_word;
  logic signed [31:0] scaled_value;
  logic range_error;

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  draw_scoreboard board;

  well512_random_generator u_dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .func         (func),
    .seed_word    (seed_word),
    .range_min    (range_min),
    .range_max    (range_max),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .raw_word     (raw_word),
    .scaled_value (scaled_value),
    .range_error  (range_error)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Receiver side: random back-pressure and checking of every accepted result beat.
  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_stall_pct);
    if (!rst && out_valid && out_ready) begin
      board.check_draw(raw_word, scaled_value, range_error);
    end
  end

  task automatic send_beat(logic f, logic [31:0] seed, logic [31:0] mn, logic [31:0] mx);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    func <= f;
    seed_word <= seed;
    range_min <= mn;
    range_max <= mx;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    board.note_beat(f, seed, mn, mx);
  endtask

  task automatic do_draw(logic [31:0] mn, logic [31:0] mx);
    send_beat(CMD_DRAW, $urandom, mn, mx);
  endtask

  task automatic do_reseed(logic [31:0] seed);
    send_beat(CMD_SEED, seed, $urandom, $urandom);
  endtask

  initial begin
    logic [31:0] mn, mx;
    board = new();
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // Directed beats: range extremes, empty and inverted ranges, seed corners.
    do_draw(32'd0, 32'd100);
    do_draw(INT_MIN_W, INT_MAX_W);
    do_draw(INT_MAX_W, INT_MIN_W);
    do_draw(32'd5, 32'd5);
    do_draw(32'hffff_ffff, 32'd0);
    do_draw(32'd0, 32'd1);
    do_draw(INT_MAX_W - 32'd1, INT_MAX_W);
    do_draw(INT_MIN_W, INT_MIN_W + 32'd1);
    do_draw(32'd0, INT_MAX_W);
    do_draw(INT_MIN_W, 32'd0);
    send_beat(CMD_DRAW, 32'hffff_ffff, 32'd7, 32'd3);
    do_reseed(32'd0);
    do_draw(-32'sd1000, 32'sd1000);
    do_reseed(32'hffff_ffff);
    do_draw(INT_MIN_W, INT_MAX_W);
    do_reseed(32'h8000_0000);
    do_reseed(32'h1234_5678);
    for (int i = 0; i < 6; i++) begin
      do_draw($urandom, $urandom);
    end

    for (int n = 0; n < NUM_RANDOM; n++) begin
      if (n % PHASE_LEN == 0) begin
        case (n / PHASE_LEN)
          1: begin
            send_idle_pct = 75;
            recv_stall_pct = 0;
          end
          2: begin
            send_idle_pct = 0;
            recv_stall_pct = 75;
          end
          3: begin
            send_idle_pct = 35;
            recv_stall_pct = 35;
          end
          default: begin
            send_idle_pct = 0;
            recv_stall_pct = 0;
          end
        endcase
      end
      if ($urandom_range(99) < 8) begin
        case ($urandom_range(3))
          0: do_reseed(32'd0);
          1: do_reseed(32'hffff_ffff);
          default: do_reseed($urandom);
        endcase
      end else begin
        case ($urandom_range(9))
          0, 1: begin
            mn = $urandom;
            mx = $urandom;
          end
          2: begin
            // Empty or inverted range.
            mn = $urandom;
            mx = mn - $urandom_range(3);
            if ($signed(mx) > $signed(mn)) mx = mn;
          end
          3: begin
            case ($urandom_range(3))
              0: mn = INT_MIN_W;
              1: mn = INT_MAX_W;
              2: mn = 32'hffff_ffff;
              default: mn = 32'd0;
            endcase
            case ($urandom_range(3))
              0: mx = INT_MIN_W;
              1: mx = INT_MAX_W;
              2: mx = 32'hffff_ffff;
              default: mx = 32'd0;
            endcase
          end
          4, 5: begin
            mn = $urandom;
            mx = mn + $urandom_range(1, 100);
          end
          default: begin
            mn = $urandom_range(65535) - 32'd32768;
            mx = mn + $urandom_range(1, 65535);
          end
        endcase
        do_draw(mn, mx);
      end
    end

    in_valid <= 1'b0;
    while (board.pending_draws.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (board.errors == 0 && board.pending_draws.size() == 0) begin
      $display("well512_random_generator test passed");
    end else begin
      $display("well512_random_generator test failed");
    end
    $finish;
  end

  initial begin
    #5000000;
    $display("well512_random_generator test failed");
    $finish;
  end

endmodule
